@@ rtl/stb_pkg.sv @@
// ----------------------------------------------------------------------------
// Software timer bank package
// Shared widths, opcodes, status codes and the front-to-back command type.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int MaxTimers = 16;
  localparam int IdBits    = 16;
  localparam int SlotBits  = $clog2(MaxTimers);
  localparam int CntBits   = $clog2(MaxTimers + 1);
  localparam int QDepth    = 2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t     op;
    logic [31:0] period;
    logic        repeat_flag;
    logic [15:0] target_id;
    logic [31:0] step;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] timer_id;
    logic        fired;
    logic [31:0] now_ms;
    logic        last;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_PACK,
    BK_DONE
  } bk_state_t;

endpackage

@@ rtl/software_timer_bank_core.sv @@
// ----------------------------------------------------------------------------
// Software timer bank core
// A command passes the front queue, then the back end's scan, pack and done
// states. Add, remove and the unused opcode give one result word from the done
// state. A tick gives its fired words from the scan state, one per cycle while
// the output is not stalled; a tick without expiry answers from the done state.
// The back end takes a new command from the queue only when idle. Synchronous
// reset clears all timers, sets the next id to 1 and time to 0.
// ----------------------------------------------------------------------------
module software_timer_bank_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode, period, repeat_flag, target_id, step, zero fill
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status, timer_id, fired, now_ms, zero fill
  output logic [55:0] m_tdata,
  output logic        m_tlast
);

  logic          q_valid, q_ready;
  stb_pkg::cmd_t q_cmd;
  stb_pkg::res_t res;

  stb_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .q_valid, .q_ready, .q_cmd
  );

  stb_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .r_valid(m_tvalid), .r_ready(m_tready), .r_data(res)
  );

  assign m_tdata = {5'd0, res.now_ms, res.fired, res.timer_id, res.status};
  assign m_tlast = res.last;

endmodule

@@ rtl/stb_front.sv @@
// ----------------------------------------------------------------------------
// Software timer bank front end
// Accepts input words, decodes the opcode and queues commands for the back end.
// ----------------------------------------------------------------------------
module stb_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [87:0]   s_tdata,
  output logic          q_valid,
  input  logic          q_ready,
  output stb_pkg::cmd_t q_cmd
);

  stb_pkg::cmd_t mem [stb_pkg::QDepth];
  logic          wptr, rptr;
  logic [1:0]    count;
  stb_pkg::cmd_t in_cmd;
  logic          push, pop;

  always_comb begin
    in_cmd.op          = stb_pkg::opcode_t'(s_tdata[1:0]);
    in_cmd.period      = s_tdata[33:2];
    in_cmd.repeat_flag = s_tdata[34];
    in_cmd.target_id   = s_tdata[50:35];
    in_cmd.step        = s_tdata[82:51];
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_cmd;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("Queue count overflow.");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd2) |-> !s_tready)
    else $error("Full queue accepted a word.");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd0) |-> !q_valid)
    else $error("Empty queue offered a command.");

endmodule

@@ rtl/stb_back.sv @@
// ----------------------------------------------------------------------------
// Software timer bank back end
// Holds the timer slots, runs one command and emits its result words.
// ----------------------------------------------------------------------------
module stb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  stb_pkg::cmd_t q_cmd,
  output logic          r_valid,
  input  logic          r_ready,
  output stb_pkg::res_t r_data
);

  localparam int N = stb_pkg::MaxTimers;

  stb_pkg::bk_state_t state, state_next;
  stb_pkg::cmd_t      cmd;

  logic [N-1:0]        valid;
  logic [15:0]         sid      [N];
  logic [31:0]         sint     [N];
  logic [31:0]         sela     [N];
  logic [N-1:0]        srep;
  logic [N-1:0]        hit;
  logic [stb_pkg::IdBits-1:0] next_id;
  logic [31:0]         time_now;
  logic [stb_pkg::SlotBits-1:0] idx;
  logic                any_fire;
  logic                found;

  logic [32:0] tsum;
  logic [32:0] esum [N];
  logic [31:0] enew [N];
  logic [N-1:0] full_hit;
  logic [stb_pkg::SlotBits-1:0] first_free;
  logic        is_full;
  logic [stb_pkg::SlotBits-1:0] pick;
  logic        pick_ok;
  logic [stb_pkg::IdBits-1:0] id_inc;
  logic        r_load;

  assign tsum = {1'b0, time_now} + {1'b0, cmd.step};

  always_comb begin
    is_full    = &valid;
    first_free = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        first_free = stb_pkg::SlotBits'(i);
      end
    end
    for (int i = 0; i < N; i++) begin
      esum[i] = {1'b0, sela[i]} + {1'b0, cmd.step};
      enew[i] = esum[i][32] ? 32'hFFFF_FFFF : esum[i][31:0];
      full_hit[i] = valid[i] && (sid[i] == 16'(cmd.target_id));
    end
    pick_ok = 1'b0;
    pick    = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (hit[i] && (stb_pkg::SlotBits'(i) >= idx)) begin
        pick_ok = 1'b1;
        pick    = stb_pkg::SlotBits'(i);
      end
    end
    id_inc = next_id + 1'b1;
    if (id_inc == '0) begin
      id_inc = stb_pkg::IdBits'(1);
    end
  end

  assign r_load = (!r_valid || r_ready) &&
                  (((state == stb_pkg::BK_SCAN) && (cmd.op == stb_pkg::OP_TICK) &&
                    found && pick_ok) ||
                   ((state == stb_pkg::BK_DONE) && !any_fire));

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    unique case (state)
      stb_pkg::BK_IDLE: begin
        q_ready = !r_valid || r_ready;
        if (q_valid && q_ready) begin
          state_next = stb_pkg::BK_SCAN;
        end
      end
      stb_pkg::BK_SCAN: begin
        if (cmd.op == stb_pkg::OP_TICK) begin
          if (found && (!r_valid || r_ready)) begin
            if (!pick_ok || (pick == stb_pkg::SlotBits'(N - 1))) begin
              state_next = stb_pkg::BK_PACK;
            end
          end
        end else begin
          state_next = stb_pkg::BK_PACK;
        end
      end
      stb_pkg::BK_PACK: state_next = stb_pkg::BK_DONE;
      stb_pkg::BK_DONE: begin
        if (!r_valid || r_ready) begin
          state_next = stb_pkg::BK_IDLE;
        end
      end
      default: state_next = stb_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stb_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (r_load) begin
      r_valid <= 1'b1;
    end else if (r_ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    logic [stb_pkg::SlotBits-1:0] w;
    if (rst) begin
      valid    <= '0;
      next_id  <= stb_pkg::IdBits'(1);
      time_now <= '0;
      hit      <= '0;
      idx      <= '0;
      any_fire <= 1'b0;
      found    <= 1'b0;
    end else begin
      unique case (state)
        stb_pkg::BK_IDLE: begin
          if (q_valid && q_ready) begin
            cmd      <= q_cmd;
            idx      <= '0;
            any_fire <= 1'b0;
            found    <= 1'b0;
          end
        end
        stb_pkg::BK_SCAN: begin
          unique case (cmd.op)
            stb_pkg::OP_ADD: begin
              if (!is_full) begin
                valid[first_free] <= 1'b1;
                sid[first_free]   <= 16'(next_id);
                sint[first_free]  <= cmd.period;
                sela[first_free]  <= '0;
                srep[first_free]  <= cmd.repeat_flag;
                next_id           <= id_inc;
              end
              found <= !is_full;
              cmd.target_id <= 16'(next_id);
            end
            stb_pkg::OP_REMOVE: begin
              found <= |full_hit;
              valid <= valid & ~full_hit;
            end
            stb_pkg::OP_TICK: begin
              if (!found) begin
                found    <= 1'b1;
                time_now <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
                for (int i = 0; i < N; i++) begin
                  if (valid[i]) begin
                    if (enew[i] >= sint[i]) begin
                      hit[i]  <= 1'b1;
                      sela[i] <= '0;
                      if (!srep[i] || sint[i] == '0) begin
                        valid[i] <= 1'b0;
                      end
                    end else begin
                      sela[i] <= enew[i];
                    end
                  end
                end
              end else if (!r_valid || r_ready) begin
                if (pick_ok) begin
                  r_data.status   <= stb_pkg::ST_OK;
                  r_data.timer_id <= sid[pick];
                  r_data.fired    <= 1'b1;
                  r_data.now_ms   <= time_now;
                  r_data.last     <= (pick == stb_pkg::SlotBits'(N - 1)) ||
                                     ((hit >> pick) >> 1) == '0;
                  hit[pick]       <= 1'b0;
                  any_fire        <= 1'b1;
                  idx             <= pick;
                end
              end
            end
            default: begin
            end
          endcase
        end
        stb_pkg::BK_PACK: begin
          w = '0;
          for (int r = 0; r < N; r++) begin
            if (valid[r]) begin
              sid[w]   <= sid[r];
              sint[w]  <= sint[r];
              sela[w]  <= sela[r];
              srep[w]  <= srep[r];
              w = w + 1'b1;
            end
          end
          for (int r = 0; r < N; r++) begin
            valid[r] <= (r < $countones(valid));
          end
          hit <= '0;
        end
        stb_pkg::BK_DONE: begin
          if ((!r_valid || r_ready) && !any_fire) begin
            r_data.fired    <= 1'b0;
            r_data.now_ms   <= time_now;
            r_data.last     <= 1'b1;
            unique case (cmd.op)
              stb_pkg::OP_ADD: begin
                r_data.status   <= found ? stb_pkg::ST_OK : stb_pkg::ST_FULL;
                r_data.timer_id <= found ? cmd.target_id : 16'd0;
              end
              stb_pkg::OP_REMOVE: begin
                r_data.status   <= found ? stb_pkg::ST_OK : stb_pkg::ST_NOT_FOUND;
                r_data.timer_id <= '0;
              end
              default: begin
                r_data.status   <= stb_pkg::ST_OK;
                r_data.timer_id <= '0;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) next_id != '0)
    else $error("Timer id reached zero.");
  assert property (@(posedge clk) disable iff (rst)
    (r_valid && !r_ready) |=> r_valid)
    else $error("Pending result word dropped.");
  assert property (@(posedge clk) disable iff (rst)
    (state == stb_pkg::BK_DONE) |=> ((hit == '0)))
    else $error("Fired flags left after packing.");

endmodule
